[hw/rtl/sctok_pkg.sv]
// Shared types and constants for the serial command-line tokenizer.
// No dependencies; used by sctok_core, sctok_out_reg and the top level.
`default_nettype none

package sctok_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic {
		KIND_CHAR     = 1'b0,
		KIND_LINE_END = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   char_value;
		logic [3:0]   token_number;
		logic         token_begins;
		logic [3:0]   token_count;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/sctok_core.sv]
// Line/token state and per-byte classification for the tokenizer.
// Depends on sctok_pkg (character codes, result_t).
`default_nettype none

module sctok_core #(
	parameter int LINE_CAPACITY = 64,
	parameter int PARAM_LIMIT   = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	output sctok_pkg::result_t    res,
	output logic                  produced
);

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam int TW = $clog2(PARAM_LIMIT + 2);

	logic [CW-1:0] stored_count_q, stored_count_d;
	logic [TW-1:0] tokens_found_q, tokens_found_d;
	logic          inside_token_q, inside_token_d;
	logic          text_ended_q, text_ended_d;

	logic is_lf, is_end;

	always_comb begin
		is_lf          = (rx_byte == sctok_pkg::CH_LF);
		is_end         = is_lf || (rx_byte == sctok_pkg::CH_CR);
		stored_count_d = stored_count_q;
		tokens_found_d = tokens_found_q;
		inside_token_d = inside_token_q;
		text_ended_d   = text_ended_q;
		produced       = 1'b0;
		res            = '0;
		res.kind       = sctok_pkg::KIND_CHAR;

		// LF right after a line end (or at start) is swallowed
		if (!(is_lf && stored_count_q == '0)) begin
			if (stored_count_q < CW'(LINE_CAPACITY - 1)) begin
				stored_count_d = stored_count_q + 1'b1;
				if (!text_ended_q) begin
					if (rx_byte == sctok_pkg::CH_NUL) begin
						text_ended_d   = 1'b1;
						inside_token_d = 1'b0;
					end else if (is_end || rx_byte == sctok_pkg::CH_SPACE) begin
						inside_token_d = 1'b0;
					end else if (inside_token_q) begin
						res.char_value   = rx_byte;
						res.token_number = 4'(32'(tokens_found_q) - 32'd1);
						produced         = 1'b1;
					end else if (32'(tokens_found_q) < PARAM_LIMIT + 1) begin
						tokens_found_d   = tokens_found_q + 1'b1;
						inside_token_d   = 1'b1;
						res.char_value   = rx_byte;
						res.token_number = 4'(tokens_found_q);
						res.token_begins = 1'b1;
						produced         = 1'b1;
					end
				end
			end
			if (is_end) begin
				res      = '0;
				res.kind = sctok_pkg::KIND_LINE_END;
				res.token_count = (32'(tokens_found_q) > 32'd15) ? 4'd15
					: 4'(tokens_found_q);
				produced       = 1'b1;
				stored_count_d = '0;
				tokens_found_d = '0;
				inside_token_d = 1'b0;
				text_ended_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			tokens_found_q <= '0;
			inside_token_q <= 1'b0;
			text_ended_q   <= 1'b0;
		end else if (step) begin
			stored_count_q <= stored_count_d;
			tokens_found_q <= tokens_found_d;
			inside_token_q <= inside_token_d;
			text_ended_q   <= text_ended_d;
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stored_count_q) <= LINE_CAPACITY - 1)
		else $error("line byte count past capacity");

	a_token_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tokens_found_q) <= PARAM_LIMIT + 1)
		else $error("token count past limit");

	a_inside_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		inside_token_q |-> (tokens_found_q != '0))
		else $error("inside a token with no token counted");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && produced && res.kind == sctok_pkg::KIND_LINE_END) |=>
		(stored_count_q == '0 && tokens_found_q == '0 && !text_ended_q))
		else $error("line end did not clear line state");

endmodule

`default_nettype wire

[hw/rtl/sctok_out_reg.sv]
// Result register for the tokenizer output channel (valid/stall).
// Depends on sctok_pkg (result_t).
`default_nettype none

module sctok_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic               load_valid,
	input  wire sctok_pkg::result_t load_res,
	input  wire logic               out_stall,
	output logic                    can_load,
	output logic                    out_valid,
	output sctok_pkg::result_t      out_res
);

	logic valid_q;
	sctok_pkg::result_t res_q;

	// register is free when empty or its word leaves this cycle
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load && load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/serial_command_line_tokenizer_unit.sv]
// Serial command-line tokenizer: top level with input register.
// Depends on sctok_pkg, sctok_core and sctok_out_reg.
//
// Takes one received byte per clock when not stalled and splits lines into a
// command token and up to PARAM_LIMIT parameter tokens (CR, LF and space
// separate; CR or LF ends the line). Each token character that is kept
// leaves as one word tagged with its token number; a line end leaves one
// word with the token count. Throughput is one byte per cycle while the
// output does not stall; a byte's result passes the input register, then the
// result register; the line state registers feed back through the
// classification logic. Bytes with no result pass without an output word.
`default_nettype none

module serial_command_line_tokenizer_unit #(
	parameter int LINE_CAPACITY = 64,
	parameter int PARAM_LIMIT   = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            result_kind,
	output logic [7:0]      char_value,
	output logic [3:0]      token_number,
	output logic            token_begins,
	output logic [3:0]      token_count
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       produced;
	sctok_pkg::result_t core_res, out_res;

	// stage 1 moves on whenever the result register can take its word
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	sctok_core #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.PARAM_LIMIT   (PARAM_LIMIT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.rx_byte  (byte_s1),
		.res      (core_res),
		.produced (produced)
	);

	sctok_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.load_valid (produced),
		.load_res   (core_res),
		.out_stall  (out_stall),
		.can_load   (advance),
		.out_valid  (out_valid),
		.out_res    (out_res)
	);

	assign result_kind  = out_res.kind;
	assign char_value   = out_res.char_value;
	assign token_number = out_res.token_number;
	assign token_begins = out_res.token_begins;
	assign token_count  = out_res.token_count;

endmodule

`default_nettype wire

[tb/sv/tb_serial_command_line_tokenizer_unit.sv]
// Testbench for serial_command_line_tokenizer_unit: byte stream in, token words out.
// Depends on sctok_pkg and the RTL top level; checks every word against a local predictor.
module tb_serial_command_line_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CAP   = 64;
	localparam int PARAM_LIM  = 8;
	localparam int IDLE_LIMIT = 1000;
	localparam int RX_ITEMS   = 750;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       result_kind;
	logic [7:0] char_value;
	logic [3:0] token_number;
	logic       token_begins;
	logic [3:0] token_count;

	logic [7:0]         rx_stream_q[$];
	sctok_pkg::result_t token_words_q[$];

	// predictor state for the current line
	int line_len;
	bit in_tok;
	int tok_cnt;
	bit text_done;

	int  errors;
	int  hold_off;
	int  stall_left;
	int  idle_cycles;
	bit  nxt_valid;
	bit  rx_burst;
	bit  tx_burst;

	serial_command_line_tokenizer_unit #(
		.LINE_CAPACITY(LINE_CAP),
		.PARAM_LIMIT(PARAM_LIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.char_value(char_value),
		.token_number(token_number),
		.token_begins(token_begins),
		.token_count(token_count)
	);

	always #4 clk = ~clk;

	task automatic tokenize_byte(input logic [7:0] b);
		sctok_pkg::result_t w;
		bit      is_end;
		is_end = (b == sctok_pkg::CH_LF) || (b == sctok_pkg::CH_CR);
		w = '0;
		// LF on an empty line (e.g. after CR) is swallowed
		if (b == sctok_pkg::CH_LF && line_len == 0)
			return;
		if (line_len < LINE_CAP - 1) begin
			line_len++;
			if (!text_done) begin
				if (b == sctok_pkg::CH_NUL) begin
					text_done = 1'b1;
					in_tok = 1'b0;
				end else if (is_end || b == sctok_pkg::CH_SPACE) begin
					in_tok = 1'b0;
				end else if (in_tok) begin
					w.kind = sctok_pkg::KIND_CHAR;
					w.char_value = b;
					w.token_number = 4'(tok_cnt - 1);
					w.token_begins = 1'b0;
					token_words_q.push_back(w);
				end else if (tok_cnt < PARAM_LIM + 1) begin
					tok_cnt++;
					in_tok = 1'b1;
					w.kind = sctok_pkg::KIND_CHAR;
					w.char_value = b;
					w.token_number = 4'(tok_cnt - 1);
					w.token_begins = 1'b1;
					token_words_q.push_back(w);
				end
			end
		end
		if (is_end) begin
			w = '0;
			w.kind = sctok_pkg::KIND_LINE_END;
			w.token_count = (tok_cnt > 15) ? 4'd15 : 4'(tok_cnt);
			token_words_q.push_back(w);
			line_len = 0;
			in_tok = 1'b0;
			tok_cnt = 0;
			text_done = 1'b0;
		end
	endtask

	task automatic cmp_field(input string field, input logic [7:0] exp, input logic [7:0] act);
		if (act !== exp) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp, act);
		end
	endtask

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		do begin
			b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(33, 126));
		end while (b == sctok_pkg::CH_CR || b == sctok_pkg::CH_LF
			|| b == sctok_pkg::CH_SPACE || b == sctok_pkg::CH_NUL);
		return b;
	endfunction

	// command plus parameters; sometimes too many tokens, too long, or cut by a zero byte
	task automatic add_command_line();
		int n_tok;
		int max_len;
		int tok_len;
		n_tok = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5);
		max_len = ($urandom_range(0, 9) == 0) ? 20 : 6;
		repeat ($urandom_range(0, 2)) rx_stream_q.push_back(sctok_pkg::CH_SPACE);
		for (int i = 0; i < n_tok; i++) begin
			tok_len = $urandom_range(1, max_len);
			repeat (tok_len) rx_stream_q.push_back(pick_text_byte());
			if ($urandom_range(0, 24) == 0)
				rx_stream_q.push_back(sctok_pkg::CH_NUL);
			else if (i < n_tok - 1 || $urandom_range(0, 1))
				repeat ($urandom_range(1, 2)) rx_stream_q.push_back(sctok_pkg::CH_SPACE);
		end
		case ($urandom_range(0, 2))
			0: rx_stream_q.push_back(sctok_pkg::CH_CR);
			1: rx_stream_q.push_back(sctok_pkg::CH_LF);
			default: begin
				rx_stream_q.push_back(sctok_pkg::CH_CR);
				rx_stream_q.push_back(sctok_pkg::CH_LF);
			end
		endcase
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 16)) begin
			case ($urandom_range(0, 7))
				0: rx_stream_q.push_back(sctok_pkg::CH_CR);
				1: rx_stream_q.push_back(sctok_pkg::CH_LF);
				2: rx_stream_q.push_back(sctok_pkg::CH_SPACE);
				3: rx_stream_q.push_back(sctok_pkg::CH_NUL);
				default: rx_stream_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// driver: one word per handshake, random hold-off before each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			hold_off = 0;
			rx_burst = 1'b0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				tokenize_byte(rx_byte);
				nxt_valid = 1'b0;
				if ($urandom_range(0, 39) == 0)
					rx_burst = ~rx_burst;
				hold_off = draw_wait(rx_burst);
			end
			if (!nxt_valid) begin
				if (hold_off > 0)
					hold_off--;
				else if (rx_stream_q.size() > 0) begin
					rx_byte <= rx_stream_q.pop_front();
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// monitor: checks each accepted word, then stalls for a random stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			tx_burst = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (token_words_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected word, expected none actual kind %0h char %0h",
						$time, result_kind, char_value);
				end else begin
					sctok_pkg::result_t w;
					w = token_words_q.pop_front();
					cmp_field("result_kind", w.kind, result_kind);
					cmp_field("char_value", w.char_value, char_value);
					cmp_field("token_number", w.token_number, token_number);
					cmp_field("token_begins", w.token_begins, token_begins);
					cmp_field("token_count", w.token_count, token_count);
				end
				if ($urandom_range(0, 39) == 0)
					tx_burst = ~tx_burst;
				stall_left = draw_wait(tx_burst);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] directed[];
		directed = {
			sctok_pkg::CH_LF,
			8'h47, 8'h4F, sctok_pkg::CH_CR, sctok_pkg::CH_LF,
			sctok_pkg::CH_CR,
			8'hFF, 8'h01, sctok_pkg::CH_SPACE, 8'h37, sctok_pkg::CH_SPACE,
			sctok_pkg::CH_SPACE, 8'h78, sctok_pkg::CH_LF,
			8'h61, sctok_pkg::CH_NUL, 8'h62, sctok_pkg::CH_SPACE, 8'h63, sctok_pkg::CH_CR,
			sctok_pkg::CH_SPACE, 8'h80, 8'h7F, sctok_pkg::CH_LF
		};
		errors = 0;
		line_len = 0;
		in_tok = 1'b0;
		tok_cnt = 0;
		text_done = 1'b0;
		foreach (directed[i])
			rx_stream_q.push_back(directed[i]);
		while (rx_stream_q.size() < directed.size() + RX_ITEMS) begin
			if ($urandom_range(0, 9) < 8)
				add_command_line();
			else
				add_noise();
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_stream_q.size() != 0 || in_valid)
			@(negedge clk);
		while (token_words_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		// a word still waiting here is one the predictor never expected
		if (errors == 0 && token_words_q.size() == 0 && !out_valid)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
